// ----- src/cbs_pkg.sv -----
// Shared types, constants and helpers of the centred binomial sampler.
`default_nettype none
package cbs_pkg;

  localparam int NUM_COEFFS  = 256;
  localparam int CNT_W       = $clog2(NUM_COEFFS) + 1;
  localparam int BUF_W       = 13;
  localparam int HELD_W      = 4;
  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CNT_W-1:0]  COEFF_LIMIT = CNT_W'(NUM_COEFFS);
  localparam logic [CNT_W-1:0]  LAST_INDEX  = CNT_W'(NUM_COEFFS - 1);
  localparam logic [1:0]        ETA_WIDE    = 2'd3;
  localparam logic [1:0]        ETA_RESET   = 2'd2;
  localparam logic [HELD_W-1:0] WIDTH_ETA2  = 4'd4;
  localparam logic [HELD_W-1:0] WIDTH_ETA3  = 4'd6;
  localparam logic [HELD_W-1:0] BYTE_BITS   = 4'd8;

  typedef struct packed {
    logic signed [2:0] coefficient;
    logic [7:0]        coeff_index;
    logic              poly_done;
  } result_t;

  // One queue entry holds every result of one byte.
  typedef struct packed {
    result_t first;
    result_t second;
    logic    two;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [1:0] ones3(input logic [2:0] v);
    ones3 = 2'(v[0]) + 2'(v[1]) + 2'(v[2]);
  endfunction

  // Low half minus high half; a narrow eta takes its halves from the low four bits only.
  function automatic logic signed [2:0] cbd_value(input logic [5:0] bits,
                                                 input logic wide);
    logic [1:0] a;
    logic [1:0] b;
    a = wide ? ones3(bits[2:0]) : ones3({1'b0, bits[1:0]});
    b = wide ? ones3(bits[5:3]) : ones3({1'b0, bits[3:2]});
    cbd_value = signed'(3'({1'b0, a}) - 3'({1'b0, b}));
  endfunction

endpackage
`default_nettype wire

// ----- src/cbs_in_if.sv -----
// Input channel: random byte and polynomial start flag.
`default_nettype none
interface cbs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rand_byte;
  logic       start_poly;

  modport source (output valid, rand_byte, start_poly, input ready);
  modport sink   (input valid, rand_byte, start_poly, output ready);
endinterface
`default_nettype wire

// ----- src/cbs_out_if.sv -----
// Output channel: one sampled coefficient per transaction.
`default_nettype none
interface cbs_out_if;
  logic              valid;
  logic              ready;
  logic signed [2:0] coefficient;
  logic [7:0]        coeff_index;
  logic              poly_done;
  logic              last_of_byte;

  modport source (output valid, coefficient, coeff_index, poly_done, last_of_byte,
                  input ready);
  modport sink   (input valid, coefficient, coeff_index, poly_done, last_of_byte,
                  output ready);
endinterface
`default_nettype wire

// ----- src/centered_binomial_sampler_top.sv -----
// Top level of the centred binomial sampler.
// Bytes arrive on in_ch and are read as a bit stream, least significant bit first; each
// coefficient takes six bits with eta 3 and four with any other value, and is the
// count of ones in the low half minus the count in the high half. A byte with start_poly
// set begins a new polynomial; after 256 coefficients further bytes are taken and dropped.
// The front end accepts a byte and stores all of its results, up to two, as one entry
// in a two-entry queue; the back end sends them on out_ch one per cycle while out_ch is
// ready. The single output port therefore sets the byte rate: eta 2 yields two
// coefficients per byte, eta 3 fewer on average.
// Write eta through eta_we/eta_wdata only while no results are pending.
`default_nettype none
module centered_binomial_sampler_top
  import cbs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       eta_we,
  input  wire logic [1:0] eta_wdata,
  cbs_in_if.sink          in_ch,
  cbs_out_if.source       out_ch
);

  logic      push;
  logic      pop;
  entry_t    push_data;
  entry_t    head;
  q_status_t q_status;

  cbs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .eta_we    (eta_we),
    .eta_wdata (eta_wdata),
    .in_ch     (in_ch),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data)
  );

  cbs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  cbs_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_status (q_status),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule
`default_nettype wire

// ----- src/cbs_front.sv -----
// Front end: eta register, bit buffer and coefficient counter; samples a byte.
`default_nettype none
module cbs_front
  import cbs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       eta_we,
  input  wire logic [1:0] eta_wdata,
  cbs_in_if.sink          in_ch,
  input  wire q_status_t  q_status,
  output logic            push,
  output entry_t          push_data
);

  logic [1:0]        eta;
  logic [BUF_W-1:0]  bit_buffer;
  logic [HELD_W-1:0] bits_held;
  logic [CNT_W-1:0]  coeff_count;

  logic [BUF_W-1:0]  bit_buffer_next;
  logic [HELD_W-1:0] bits_held_next;
  logic [CNT_W-1:0]  coeff_count_next;

  logic              wide;
  logic [HELD_W-1:0] width;
  logic [BUF_W-1:0]  buf0, merged, buf_a, buf_b;
  logic [HELD_W-1:0] held0, held1, held_a, held_b;
  logic [CNT_W-1:0]  cnt0, cnt_a, cnt_b;
  logic              active, take0, take1;
  logic              accept;

  assign in_ch.ready = !q_status.full;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    wide  = (eta == ETA_WIDE);
    width = wide ? WIDTH_ETA3 : WIDTH_ETA2;

    buf0  = in_ch.start_poly ? '0 : bit_buffer;
    held0 = in_ch.start_poly ? '0 : bits_held;
    cnt0  = in_ch.start_poly ? '0 : coeff_count;

    active = (cnt0 < COEFF_LIMIT);
    merged = buf0 | (BUF_W'(in_ch.rand_byte) << held0[2:0]);
    held1  = held0 + BYTE_BITS;

    take0  = active && (held1 >= width);
    buf_a  = merged >> width;
    held_a = held1 - width;
    cnt_a  = cnt0 + CNT_W'(1);

    take1  = take0 && (held_a >= width) && (cnt_a < COEFF_LIMIT);
    buf_b  = buf_a >> width;
    held_b = held_a - width;
    cnt_b  = cnt_a + CNT_W'(1);

    push_data.first.coefficient  = cbd_value(merged[5:0], wide);
    push_data.first.coeff_index  = cnt0[7:0];
    push_data.first.poly_done    = (cnt0 == LAST_INDEX);
    push_data.second.coefficient = cbd_value(buf_a[5:0], wide);
    push_data.second.coeff_index = cnt_a[7:0];
    push_data.second.poly_done   = (cnt_a == LAST_INDEX);
    push_data.two                = take1;
    push                         = accept && take0;

    // Drop bytes once the polynomial is full, keeping only the start clear.
    if (!active) begin
      bit_buffer_next  = buf0;
      bits_held_next   = held0;
      coeff_count_next = cnt0;
    end else if (take1) begin
      bit_buffer_next  = buf_b;
      bits_held_next   = held_b;
      coeff_count_next = cnt_b;
    end else if (take0) begin
      bit_buffer_next  = buf_a;
      bits_held_next   = held_a;
      coeff_count_next = cnt_a;
    end else begin
      bit_buffer_next  = merged;
      bits_held_next   = held1;
      coeff_count_next = cnt0;
    end
    if (active && (coeff_count_next >= COEFF_LIMIT)) begin
      bit_buffer_next = '0;
      bits_held_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eta         <= ETA_RESET;
      bit_buffer  <= '0;
      bits_held   <= '0;
      coeff_count <= '0;
    end else begin
      if (eta_we) begin
        eta <= eta_wdata;
      end
      if (accept) begin
        bit_buffer  <= bit_buffer_next;
        bits_held   <= bits_held_next;
        coeff_count <= coeff_count_next;
      end
    end
  end

endmodule
`default_nettype wire

// ----- src/cbs_queue.sv -----
// Short queue of per-byte result entries between front and back end.
`default_nettype none
module cbs_queue
  import cbs_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire entry_t push_data,
  input  wire logic   pop,
  output entry_t      head,
  output q_status_t   status
);

  entry_t            mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0] count;

  assign status.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign head         = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers wrap naturally: the depth is a power of two.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ----- src/cbs_back.sv -----
// Back end: issues the results of the head entry one per transaction.
`default_nettype none
module cbs_back
  import cbs_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire entry_t    head,
  input  wire q_status_t q_status,
  output logic           pop,
  cbs_out_if.source      out_ch
);

  logic    sel;
  logic    last;
  logic    accept;
  result_t cur;

  assign cur    = sel ? head.second : head.first;
  assign last   = sel || !head.two;
  assign accept = out_ch.valid && out_ch.ready;
  assign pop    = accept && last;

  assign out_ch.valid        = !q_status.empty;
  assign out_ch.coefficient  = cur.coefficient;
  assign out_ch.coeff_index  = cur.coeff_index;
  assign out_ch.poly_done    = cur.poly_done;
  assign out_ch.last_of_byte = last;

  // Advance to the second result, or back to the first once the entry retires.
  always_ff @(posedge clk) begin
    if (rst) begin
      sel <= 1'b0;
    end else if (accept) begin
      sel <= !last;
    end
  end

endmodule
`default_nettype wire

// ----- verif/cbs_checker.sv -----
// Checker for the centred binomial sampler: predicts coefficients and compares transactions.
`default_nettype none
module cbs_checker
  import cbs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       eta_we,
  input  wire logic [1:0] eta_wdata,
  cbs_in_if               in_mon,
  cbs_out_if              out_mon,
  output int              fail_count,
  output int              waiting,
  output int              checked,
  output int              polys_done
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [2:0] coefficient;
    logic [7:0]        coeff_index;
    logic              poly_done;
    logic              last_of_byte;
  } coeff_t;

  coeff_t             expected_coeffs[$];
  logic [1:0]         eta_q;
  logic [BUF_W-1:0]   stream_bits;
  logic [HELD_W-1:0]  held;
  logic [CNT_W-1:0]   count;

  task automatic report(input string field, input int want_v, input int got_v);
    $error("%s mismatch: expected %0d, got %0d", field, want_v, got_v);
    fail_count++;
  endtask

  // Take one byte into the stream and queue the coefficients it completes.
  task automatic sample_byte(input logic [7:0] b, input logic s);
    logic              wide;
    logic [HELD_W-1:0] w;
    logic [2:0]        hmask;
    logic [2:0]        lo;
    logic [2:0]        hi;
    coeff_t            made[2];
    int                n;
    wide  = (eta_q == ETA_WIDE);
    w     = wide ? WIDTH_ETA3 : WIDTH_ETA2;
    hmask = wide ? 3'b111 : 3'b011;
    n     = 0;
    if (s) begin
      stream_bits = '0;
      held        = '0;
      count       = '0;
    end
    // drop bytes once the polynomial is complete
    if (count >= COEFF_LIMIT) return;
    stream_bits = stream_bits | (BUF_W'(b) << held[2:0]);
    held        = held + BYTE_BITS;
    while (n < 2 && held >= w && count < COEFF_LIMIT) begin
      lo = stream_bits[2:0] & hmask;
      hi = (wide ? stream_bits[5:3] : {1'b0, stream_bits[3:2]}) & hmask;
      made[n].coefficient  = 3'($countones(lo) - $countones(hi));
      made[n].coeff_index  = count[7:0];
      made[n].poly_done    = (count == LAST_INDEX);
      made[n].last_of_byte = 1'b0;
      stream_bits = stream_bits >> w;
      held        = held - w;
      count       = count + CNT_W'(1);
      n++;
    end
    if (count >= COEFF_LIMIT) begin
      stream_bits = '0;
      held        = '0;
    end
    if (n > 0) made[n-1].last_of_byte = 1'b1;
    for (int k = 0; k < n; k++) expected_coeffs.push_back(made[k]);
  endtask

  always @(posedge clk) begin : monitor
    coeff_t want;
    if (rst) begin
      expected_coeffs.delete();
      eta_q       = ETA_RESET;
      stream_bits = '0;
      held        = '0;
      count       = '0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        checked++;
        if (expected_coeffs.size() == 0) begin
          $error("coefficient transaction with nothing expected: index %0d, value %0d",
                 out_mon.coeff_index, int'(out_mon.coefficient));
          fail_count++;
        end else begin
          want = expected_coeffs.pop_front();
          if (out_mon.coefficient !== want.coefficient)
            report("coefficient", int'(want.coefficient), int'(out_mon.coefficient));
          if (out_mon.coeff_index !== want.coeff_index)
            report("coeff_index", want.coeff_index, out_mon.coeff_index);
          if (out_mon.poly_done !== want.poly_done)
            report("poly_done", want.poly_done, out_mon.poly_done);
          if (out_mon.last_of_byte !== want.last_of_byte)
            report("last_of_byte", want.last_of_byte, out_mon.last_of_byte);
          if (want.poly_done) polys_done++;
        end
      end
      if (in_mon.valid && in_mon.ready) sample_byte(in_mon.rand_byte, in_mon.start_poly);
      // a write takes effect from the next byte on
      if (eta_we) eta_q = eta_wdata;
    end
    waiting = expected_coeffs.size();
  end

endmodule
`default_nettype wire

// ----- verif/tb_top.sv -----
// Testbench top: drives bytes and eta writes into the sampler and gives the verdict.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cbs_pkg::*;

  localparam int LIMIT       = 200000;
  localparam int PHASE_ITEMS = 185;

  logic       clk = 1'b0;
  logic       rst;
  logic       eta_we;
  logic [1:0] eta_wdata;
  int         idle_in_pct;
  int         stall_out_pct;
  int         bytes_sent;
  int         fail_count;
  int         waiting;
  int         checked;
  int         polys;

  cbs_in_if  in_ch();
  cbs_out_if out_ch();

  centered_binomial_sampler_top dut (
    .clk       (clk),
    .rst       (rst),
    .eta_we    (eta_we),
    .eta_wdata (eta_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  cbs_checker chk (
    .clk        (clk),
    .rst        (rst),
    .eta_we     (eta_we),
    .eta_wdata  (eta_wdata),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .waiting    (waiting),
    .checked    (checked),
    .polys_done (polys)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin : watchdog
    repeat (LIMIT) @(posedge clk);
    $display("FAIL centered_binomial_sampler_top");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input logic s);
    while ($urandom_range(99) < idle_in_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.rand_byte  <= b;
    in_ch.start_poly <= s;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
  endtask

  // Hold off until every expected coefficient is out and a dropped byte has settled.
  task automatic quiesce();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (waiting != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_eta(input logic [1:0] v);
    quiesce();
    eta_we    <= 1'b1;
    eta_wdata <= v;
    @(posedge clk);
    eta_we    <= 1'b0;
  endtask

  // Mostly long runs, whole polynomials with dropped bytes after unless eta is 3; the rest short noisy runs.
  task automatic run_phase(input int quota);
    int   sent;
    int   len;
    bit   noisy;
    logic s;
    sent = 0;
    while (sent < quota) begin
      noisy = ($urandom_range(4) == 0);
      len   = noisy ? $urandom_range(60, 1) : $urandom_range(200, 125);
      if (len > quota - sent) len = quota - sent;
      for (int k = 0; k < len; k++) begin
        if (k == 0) s = (sent == 0) ? 1'($urandom_range(1)) : 1'b1;
        else        s = noisy && ($urandom_range(7) == 0);
        send_byte(8'($urandom), s);
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    logic [1:0] eta_plan[8];
    rst              = 1'b1;
    eta_we           = 1'b0;
    eta_wdata        = ETA_RESET;
    in_ch.valid      = 1'b0;
    in_ch.rand_byte  = 8'h00;
    in_ch.start_poly = 1'b0;
    out_ch.ready     = 1'b0;
    idle_in_pct      = 0;
    stall_out_pct    = 0;
    bytes_sent       = 0;
    eta_plan = '{ETA_WIDE, ETA_RESET, 2'd0, ETA_WIDE, 2'd1, ETA_RESET, ETA_WIDE, ETA_RESET};
    fork
      forever begin
        @(posedge clk);
        out_ch.ready <= ($urandom_range(99) >= stall_out_pct);
      end
    join_none
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // eta 2 from reset: zero, all ones, extreme positive and negative halves
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'h0C, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);
    write_eta(ETA_WIDE);
    send_byte(8'h07, 1'b1);
    send_byte(8'h38, 1'b1);
    send_byte(8'hFF, 1'b0);
    // switch to eta 2 with four bits held: the next byte holds bits for three coefficients, but only two are taken
    write_eta(ETA_RESET);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h0F, 1'b0);
    write_eta(2'd1);
    send_byte(8'h33, 1'b1);
    send_byte(8'hCC, 1'b0);
    write_eta(2'd0);
    send_byte(8'h5A, 1'b1);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h81, 1'b1);
    send_byte(8'h7E, 1'b0);

    for (int p = 0; p < 8; p++) begin
      write_eta(eta_plan[p]);
      case (p % 4)
        0: begin idle_in_pct = 0;  stall_out_pct = 0;  end
        1: begin idle_in_pct = 47; stall_out_pct = 0;  end
        2: begin idle_in_pct = 0;  stall_out_pct = 47; end
        default: begin idle_in_pct = 30; stall_out_pct = 30; end
      endcase
      run_phase(PHASE_ITEMS);
    end

    stall_out_pct = 0;
    quiesce();
    repeat (16) @(posedge clk);
    $display("Sent %0d bytes, checked %0d coefficients, completed %0d polynomials,",
             bytes_sent, checked, polys);
    $display("over eta values 0 to 3 with free-running, idle-sender and stalled-receiver runs.");
    if (fail_count == 0) $display("PASS centered_binomial_sampler_top");
    else                 $display("FAIL centered_binomial_sampler_top");
    $finish;
  end

endmodule
`default_nettype wire

// ----- centered_binomial_sampler_top.f -----
src/cbs_pkg.sv
src/cbs_in_if.sv
src/cbs_out_if.sv
src/cbs_front.sv
src/cbs_queue.sv
src/cbs_back.sv
src/centered_binomial_sampler_top.sv
verif/cbs_checker.sv
verif/tb_top.sv
